### rtl/adg_pkg.sv
package adg_pkg;

	// table geometry
	localparam int ADDR_W  = 16;
	localparam int ENTRIES = 1 << ADDR_W;

	// field widths
	localparam int GRAD_W = 32;
	localparam int SUM_W  = 48;
	localparam int WGT_W  = 36;
	localparam int QUO_W  = 37;
	localparam int ROOT_W = 25;
	localparam int GS_W   = 2 * GRAD_W + 2 * SUM_W;
	localparam int WS_W   = 2 * WGT_W;

	// commands
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_LOAD   = 2'd2;

	// register indexes
	localparam logic [2:0] REG_STEP   = 3'd0;
	localparam logic [2:0] REG_FLOOR  = 3'd1;
	localparam logic [2:0] REG_WARMUP = 3'd2;
	localparam logic [2:0] REG_LOW    = 3'd3;
	localparam logic [2:0] REG_HIGH   = 3'd4;

	// register reset values
	localparam logic [23:0]        RST_STEP   = 24'd167772;
	localparam logic [24:0]        RST_FLOOR  = 25'd1677722;
	localparam logic [15:0]        RST_WARMUP = 16'd10;
	localparam logic signed [17:0] RST_LOW    = -18'sd16384;
	localparam logic [16:0]        RST_HIGH   = 17'd16383;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_CALC,
		ST_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		LN_IDLE,
		LN_SQUARE,
		LN_SUM,
		LN_ROOT,
		LN_MUL,
		LN_DIV_INIT,
		LN_DIV,
		LN_DONE
	} lane_state_t;

	typedef struct packed {
		logic [23:0] step_size;
		logic [24:0] sum_floor;
		logic        skip;
	} lane_cfg_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] sum;
		logic             move;
		logic [QUO_W-1:0] step;
	} lane_res_t;

endpackage

### rtl/adg_in_if.sv
interface adg_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [15:0]        entry;
	logic signed [31:0] grad_a;
	logic signed [31:0] grad_b;
	logic signed [17:0] load_a;
	logic signed [17:0] load_b;
	logic [31:0]        epoch;

	modport source (output valid, cmd, entry, grad_a, grad_b, load_a, load_b, epoch,
		input ready);
	modport sink (input valid, cmd, entry, grad_a, grad_b, load_a, load_b, epoch,
		output ready);
endinterface

### rtl/adg_out_if.sv
interface adg_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        out_entry;
	logic signed [17:0] weight_a;
	logic signed [17:0] weight_b;
	logic               changed;

	modport source (output valid, out_entry, weight_a, weight_b, changed, input ready);
	modport sink (input valid, out_entry, weight_a, weight_b, changed, output ready);
endinterface

### rtl/adg_ram.sv
module adg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/adg_lane.sv
// One weight component: square, saturating sum, bit-serial root and divide.
module adg_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  adg_pkg::lane_cfg_t                  cfg,
	input  logic signed [adg_pkg::GRAD_W-1:0]   grad,
	input  logic [adg_pkg::SUM_W-1:0]           sum_in,
	output adg_pkg::lane_res_t                  res
);

	adg_pkg::lane_state_t state_q, state_d;

	logic [31:0]                 mag_q;
	logic [62:0]                 prod_q;
	logic [adg_pkg::SUM_W-1:0]   sum_q;
	logic                        move_q;
	logic [47:0]                 v_q;
	logic [47:0]                 root_q;
	logic [47:0]                 bit_q;
	logic [55:0]                 num_q;
	logic [adg_pkg::ROOT_W-1:0]  div_q;
	logic [adg_pkg::QUO_W-1:0]   quo_q;
	logic [adg_pkg::ROOT_W:0]    rem_q;
	logic [5:0]                  cnt_q;

	logic [48:0]                 sum_wide;
	logic [adg_pkg::SUM_W-1:0]   sum_sat;
	logic                        move_now;
	logic [47:0]                 trial;
	logic [adg_pkg::ROOT_W:0]    rem_try;
	logic [56:0]                 dvd;

	// sum update, saturating at the top of the 48-bit range
	assign sum_wide = {1'b0, sum_q} + 49'(prod_q[62:24]);
	assign sum_sat  = sum_wide[48] ? '1 : sum_wide[47:0];
	assign move_now = !cfg.skip && (sum_sat >= 48'(cfg.sum_floor));

	assign trial   = root_q + bit_q;
	assign rem_try = {rem_q[adg_pkg::ROOT_W-1:0], quo_q[adg_pkg::QUO_W-1]};
	// rounding term of half the divisor, already scaled
	assign dvd     = 57'(num_q) + (57'(div_q) << 19);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adg_pkg::LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			adg_pkg::LN_IDLE:     if (start) state_d = adg_pkg::LN_SQUARE;
			adg_pkg::LN_SQUARE:   state_d = adg_pkg::LN_SUM;
			adg_pkg::LN_SUM:      state_d = move_now ? adg_pkg::LN_ROOT : adg_pkg::LN_DONE;
			adg_pkg::LN_ROOT:     if (bit_q[0]) state_d = adg_pkg::LN_MUL;
			adg_pkg::LN_MUL:      state_d = adg_pkg::LN_DIV_INIT;
			adg_pkg::LN_DIV_INIT: state_d = adg_pkg::LN_DIV;
			adg_pkg::LN_DIV:      if (cnt_q == 6'(adg_pkg::QUO_W - 1)) state_d = adg_pkg::LN_DONE;
			adg_pkg::LN_DONE:     state_d = adg_pkg::LN_IDLE;
			default:              state_d = adg_pkg::LN_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			adg_pkg::LN_IDLE: begin
				if (start) begin
					mag_q <= grad[31] ? 32'(-grad) : 32'(grad);
					sum_q <= sum_in;
				end
			end
			adg_pkg::LN_SQUARE: begin
				prod_q <= 63'(mag_q) * 63'(mag_q);
			end
			adg_pkg::LN_SUM: begin
				sum_q  <= sum_sat;
				move_q <= move_now;
				quo_q  <= '0;
				v_q    <= sum_sat;
				root_q <= '0;
				bit_q  <= 48'h1 << 46;
			end
			adg_pkg::LN_ROOT: begin
				if (v_q >= trial) begin
					v_q    <= v_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			adg_pkg::LN_MUL: begin
				div_q <= (root_q == '0) ? adg_pkg::ROOT_W'(1) : root_q[adg_pkg::ROOT_W-1:0];
				num_q <= 56'(cfg.step_size) * 56'(mag_q);
			end
			adg_pkg::LN_DIV_INIT: begin
				quo_q <= dvd[56:20];
				rem_q <= '0;
				cnt_q <= '0;
			end
			adg_pkg::LN_DIV: begin
				if (rem_try >= {1'b0, div_q}) begin
					rem_q <= rem_try - {1'b0, div_q};
					quo_q <= {quo_q[adg_pkg::QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_try;
					quo_q <= {quo_q[adg_pkg::QUO_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

	assign res.done = (state_q == adg_pkg::LN_DONE);
	assign res.sum  = sum_q;
	assign res.move = move_q;
	assign res.step = quo_q;

endmodule

### rtl/adagrad_weight_update_table_top.sv
// Channel   Dir  Payload
// in_ch     in   cmd, entry, grad_a, grad_b, load_a, load_b, epoch
// out_ch    out  out_entry, weight_a, weight_b, changed
// apb       in   registers at byte address 4*i
//
// One item at a time. Add and load go through the read and execute states; an
// update with moving components runs the 24-step root and 37-step divide in each
// lane (the two lanes run side by side); one with no moving component skips root
// and divide, and one with a zero pending gradient skips the lanes.
// After reset a clearing pass over all 65536 entries zeroes gradient and sum memory;
// no transfer on in_ch is taken meanwhile. A stalled out_ch holds the next update
// at its last step, and no further item is taken until it moves on.
module adagrad_weight_update_table_top (
	input  logic        clk,
	input  logic        arst_n,
	adg_in_if.sink      in_ch,
	adg_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int EXT_W = adg_pkg::ADDR_W + 16;

	adg_pkg::top_state_t state_q, state_d;

	// configuration
	logic [23:0]        step_q;
	logic [24:0]        floor_q;
	logic [15:0]        warm_q;
	logic signed [17:0] low_q;
	logic [16:0]        high_q;

	// accepted item
	logic [1:0]         cmd_q;
	logic [15:0]        entry_q;
	logic signed [31:0] ga_q;
	logic signed [31:0] gb_q;
	logic signed [17:0] la_q;
	logic signed [17:0] lb_q;
	logic [31:0]        epoch_q;

	logic [adg_pkg::ADDR_W-1:0] clr_q;
	logic                       dn_a_q, dn_b_q;

	// pending result and output register
	logic               res_chg_q;
	logic signed [17:0] res_a_q, res_b_q;
	logic               out_v_q;
	logic [15:0]        out_ent_q;
	logic signed [17:0] out_a_q, out_b_q;
	logic               out_chg_q;

	// memories
	logic                       gs_we, w_we, rd_en;
	logic [adg_pkg::ADDR_W-1:0] gs_waddr, row;
	logic [adg_pkg::GS_W-1:0]   gs_wdata, gs_rd;
	logic [adg_pkg::WS_W-1:0]   w_wdata, w_rd;
	logic [EXT_W-1:0]           ent_ext;

	logic signed [31:0] g_a, g_b;
	logic [47:0]        s_a, s_b;
	logic signed [35:0] w_a, w_b;
	logic               skip, grad_zero, lane_start, finish, out_free;

	adg_pkg::lane_cfg_t lane_cfg;
	adg_pkg::lane_res_t lres_a, lres_b;

	logic signed [39:0] hi40, lo40, nw_a, nw_b;

	function automatic logic signed [31:0] sat32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return s[31:0];
	endfunction

	// moved weight, clamped high first then low
	function automatic logic signed [39:0] move_clamp(input logic signed [35:0] w,
		input adg_pkg::lane_res_t r, input logic signed [31:0] g,
		input logic signed [39:0] hi, input logic signed [39:0] lo);
		logic signed [39:0] d, v;
		d = 40'(r.step);
		if (!r.move) begin
			d = '0;
		end else if (!g[31] && g != '0) begin
			d = -d;
		end
		v = {{4{w[35]}}, w} + d;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v;
	endfunction

	// Q23.16 to integer, halves away from zero
	function automatic logic signed [17:0] round16(input logic signed [39:0] w);
		logic [39:0] mag, r;
		mag = w[39] ? 40'(-w) : 40'(w);
		r   = (mag + 40'h8000) >> 16;
		return w[39] ? 18'(-r) : 18'(r);
	endfunction

	assign ent_ext = EXT_W'(entry_q);
	assign row     = ent_ext[adg_pkg::ADDR_W-1:0];

	assign g_a = gs_rd[159:128];
	assign g_b = gs_rd[127:96];
	assign s_a = gs_rd[95:48];
	assign s_b = gs_rd[47:0];
	assign w_a = w_rd[71:36];
	assign w_b = w_rd[35:0];

	assign skip      = epoch_q <= 32'(warm_q);
	assign grad_zero = (g_a == '0) && (g_b == '0);
	assign hi40      = {7'b0, high_q, 16'b0};
	assign lo40      = {{6{low_q[17]}}, low_q, 16'b0};
	assign nw_a      = move_clamp(w_a, lres_a, g_a, hi40, lo40);
	assign nw_b      = move_clamp(w_b, lres_b, g_b, hi40, lo40);
	assign out_free  = !out_v_q || out_ch.ready;

	assign lane_cfg.step_size = step_q;
	assign lane_cfg.sum_floor = floor_q;
	assign lane_cfg.skip      = skip;

	adg_ram #(.WIDTH(adg_pkg::GS_W), .DEPTH(adg_pkg::ENTRIES)) u_gs_ram (
		.clk(clk), .we(gs_we), .waddr(gs_waddr), .wdata(gs_wdata),
		.re(rd_en), .raddr(row), .rdata(gs_rd)
	);

	adg_ram #(.WIDTH(adg_pkg::WS_W), .DEPTH(adg_pkg::ENTRIES)) u_w_ram (
		.clk(clk), .we(w_we), .waddr(row), .wdata(w_wdata),
		.re(rd_en), .raddr(row), .rdata(w_rd)
	);

	adg_lane u_lane_a (
		.clk(clk), .arst_n(arst_n), .start(lane_start), .cfg(lane_cfg),
		.grad(g_a), .sum_in(s_a), .res(lres_a)
	);

	adg_lane u_lane_b (
		.clk(clk), .arst_n(arst_n), .start(lane_start), .cfg(lane_cfg),
		.grad(g_b), .sum_in(s_b), .res(lres_b)
	);

	assign finish = (state_q == adg_pkg::ST_CALC) && (dn_a_q || lres_a.done)
		&& (dn_b_q || lres_b.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer and memory controls
	always_comb begin
		state_d    = state_q;
		gs_we      = 1'b0;
		w_we       = 1'b0;
		rd_en      = 1'b0;
		lane_start = 1'b0;
		gs_waddr   = row;
		gs_wdata   = '0;
		w_wdata    = {{2{la_q[17]}}, la_q, 16'h0, {2{lb_q[17]}}, lb_q, 16'h0};
		in_ch.ready = 1'b0;
		unique case (state_q)
			adg_pkg::ST_CLEAR: begin
				gs_we    = 1'b1;
				gs_waddr = clr_q;
				if (&clr_q) state_d = adg_pkg::ST_IDLE;
			end
			adg_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = adg_pkg::ST_READ;
			end
			adg_pkg::ST_READ: begin
				rd_en   = 1'b1;
				state_d = adg_pkg::ST_EXEC;
			end
			adg_pkg::ST_EXEC: begin
				state_d = adg_pkg::ST_IDLE;
				case (cmd_q)
					adg_pkg::CMD_ADD: begin
						gs_we    = 1'b1;
						gs_wdata = {sat32(g_a, ga_q), sat32(g_b, gb_q), s_a, s_b};
					end
					adg_pkg::CMD_LOAD: begin
						gs_we = 1'b1;
						w_we  = 1'b1;
					end
					adg_pkg::CMD_UPDATE: begin
						if (grad_zero) begin
							state_d = adg_pkg::ST_OUT;
						end else begin
							lane_start = 1'b1;
							state_d    = adg_pkg::ST_CALC;
						end
					end
					default: begin
					end
				endcase
			end
			adg_pkg::ST_CALC: begin
				if (finish) begin
					gs_we    = 1'b1;
					gs_wdata = {64'h0, lres_a.sum, lres_b.sum};
					w_we     = !skip;
					w_wdata  = {nw_a[35:0], nw_b[35:0]};
					state_d  = adg_pkg::ST_OUT;
				end
			end
			adg_pkg::ST_OUT: begin
				if (out_free) state_d = adg_pkg::ST_IDLE;
			end
			default: state_d = adg_pkg::ST_IDLE;
		endcase
	end

	// item capture and result
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_q   <= in_ch.cmd;
			entry_q <= in_ch.entry;
			ga_q    <= in_ch.grad_a;
			gb_q    <= in_ch.grad_b;
			la_q    <= in_ch.load_a;
			lb_q    <= in_ch.load_b;
			epoch_q <= in_ch.epoch;
		end
		if (state_q == adg_pkg::ST_EXEC) begin
			res_chg_q <= 1'b0;
			res_a_q   <= '0;
			res_b_q   <= '0;
		end
		if (finish && !skip) begin
			res_chg_q <= 1'b1;
			res_a_q   <= round16(nw_a);
			res_b_q   <= round16(nw_b);
		end
		if (state_q == adg_pkg::ST_OUT && out_free) begin
			out_ent_q <= entry_q;
			out_a_q   <= res_a_q;
			out_b_q   <= res_b_q;
			out_chg_q <= res_chg_q;
		end
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			dn_a_q  <= 1'b0;
			dn_b_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == adg_pkg::ST_CLEAR) begin
				clr_q <= clr_q + adg_pkg::ADDR_W'(1);
			end
			if (lane_start) begin
				dn_a_q <= 1'b0;
				dn_b_q <= 1'b0;
			end else begin
				if (lres_a.done) dn_a_q <= 1'b1;
				if (lres_b.done) dn_b_q <= 1'b1;
			end
			if (state_q == adg_pkg::ST_OUT && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.out_entry = out_ent_q;
	assign out_ch.weight_a  = out_a_q;
	assign out_ch.weight_b  = out_b_q;
	assign out_ch.changed   = out_chg_q;

	// register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= adg_pkg::RST_STEP;
			floor_q <= adg_pkg::RST_FLOOR;
			warm_q  <= adg_pkg::RST_WARMUP;
			low_q   <= adg_pkg::RST_LOW;
			high_q  <= adg_pkg::RST_HIGH;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				adg_pkg::REG_STEP:   step_q  <= pwdata[23:0];
				adg_pkg::REG_FLOOR:  floor_q <= pwdata[24:0];
				adg_pkg::REG_WARMUP: warm_q  <= pwdata[15:0];
				adg_pkg::REG_LOW:    low_q   <= pwdata[17:0];
				adg_pkg::REG_HIGH:   high_q  <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			adg_pkg::REG_STEP:   prdata = 32'(step_q);
			adg_pkg::REG_FLOOR:  prdata = 32'(floor_q);
			adg_pkg::REG_WARMUP: prdata = 32'(warm_q);
			adg_pkg::REG_LOW:    prdata = {{14{low_q[17]}}, low_q};
			adg_pkg::REG_HIGH:   prdata = 32'(high_q);
			default:             prdata = '0;
		endcase
	end

	assign pready = 1'b1;

endmodule

### rtl/adg_checker.sv
module adg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic signed [17:0] weight_a,
	input logic signed [17:0] weight_b,
	input logic        changed
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: busy after every input transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result only comes out of a busy cycle
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

	// unchanged results carry zero weights
	a_zero_wgt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !changed |-> weight_a == 18'sd0 && weight_b == 18'sd0)
		else $error("unchanged result with weight");

endmodule

bind adagrad_weight_update_table_top adg_checker u_adg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.weight_a(out_ch.weight_a),
	.weight_b(out_ch.weight_b),
	.changed(out_ch.changed)
);

### test/tb_adagrad_weight_update_table_top.sv
`timescale 1ns / 1ps

module tb_adagrad_weight_update_table_top;

	// command code that the block ignores
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam longint unsigned SUM_SAT = 64'hFFFF_FFFF_FFFF;
	localparam int PHASE_ITEMS = 235;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 200;

	typedef struct {
		logic [1:0]         cmd;
		logic [15:0]        entry;
		logic signed [31:0] grad_a;
		logic signed [31:0] grad_b;
		logic signed [17:0] load_a;
		logic signed [17:0] load_b;
		logic [31:0]        epoch;
	} upd_item_t;

	typedef struct {
		logic [15:0]        out_entry;
		logic signed [17:0] weight_a;
		logic signed [17:0] weight_b;
		logic               changed;
	} weight_res_t;

	// weight table model and store of expected update results
	class weight_table_sb;
		int                weight_errs;
		weight_res_t       upd_expected[$];
		longint            wgt[adg_pkg::ENTRIES][2];
		int                pend[adg_pkg::ENTRIES][2];
		longint unsigned   gsum[adg_pkg::ENTRIES][2];
		longint unsigned   step_size;
		longint unsigned   sum_floor;
		longint unsigned   warmup;
		longint            lim_low;
		longint            lim_high;

		function new();
			weight_errs = 0;
			step_size   = adg_pkg::RST_STEP;
			sum_floor   = adg_pkg::RST_FLOOR;
			warmup      = adg_pkg::RST_WARMUP;
			lim_low     = adg_pkg::RST_LOW;
			lim_high    = adg_pkg::RST_HIGH;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			logic signed [17:0] lo;
			lo = v[17:0];
			case (idx)
				adg_pkg::REG_STEP:   step_size = v[23:0];
				adg_pkg::REG_FLOOR:  sum_floor = v[24:0];
				adg_pkg::REG_WARMUP: warmup = v[15:0];
				adg_pkg::REG_LOW:    lim_low = lo;
				adg_pkg::REG_HIGH:   lim_high = v[16:0];
				default: ;
			endcase
		endfunction

		function int sat_add(int a, int b);
			longint s;
			s = longint'(a) + longint'(b);
			if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
			if (s < -64'sd2147483648) return 32'h8000_0000;
			return int'(s);
		endfunction

		function longint unsigned root48(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 46;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function logic [17:0] round_int(longint w);
			longint r;
			r = ((w < 0 ? -w : w) + 32768) >>> 16;
			r = (w < 0) ? -r : r;
			return r[17:0];
		endfunction

		// note one accepted input transfer
		function void note_item(upd_item_t it);
			int unsigned     row;
			weight_res_t     e;
			bit              skip;
			int              g;
			longint unsigned mag, sq, s, r, den, num, d;
			longint          w;
			row = it.entry;
			case (it.cmd)
				adg_pkg::CMD_ADD: begin
					pend[row][0] = sat_add(pend[row][0], it.grad_a);
					pend[row][1] = sat_add(pend[row][1], it.grad_b);
				end
				adg_pkg::CMD_LOAD: begin
					wgt[row][0] = longint'(it.load_a) * 65536;
					wgt[row][1] = longint'(it.load_b) * 65536;
					pend[row] = '{0, 0};
					gsum[row] = '{0, 0};
				end
				adg_pkg::CMD_UPDATE: begin
					e.out_entry = it.entry;
					e.weight_a  = 0;
					e.weight_b  = 0;
					e.changed   = 0;
					if (pend[row][0] != 0 || pend[row][1] != 0) begin
						skip = longint'(it.epoch) <= warmup;
						for (int c = 0; c < 2; c++) begin
							g = pend[row][c];
							mag = (g < 0) ? -longint'(g) : longint'(g);
							sq = (mag * mag) >> 24;
							s = gsum[row][c] + sq;
							if (s > SUM_SAT) s = SUM_SAT;
							gsum[row][c] = s;
							if (!skip && s >= sum_floor) begin
								r = root48(s);
								if (r == 0) r = 1;
								den = r << 20;
								num = step_size * mag;
								d = (num + (den >> 1)) / den;
								if (g > 0) wgt[row][c] -= longint'(d);
								else wgt[row][c] += longint'(d);
							end
							pend[row][c] = 0;
						end
						if (!skip) begin
							for (int c = 0; c < 2; c++) begin
								w = wgt[row][c];
								if (w > lim_high * 65536) w = lim_high * 65536;
								if (w < lim_low * 65536) w = lim_low * 65536;
								wgt[row][c] = w;
							end
							e.weight_a = round_int(wgt[row][0]);
							e.weight_b = round_int(wgt[row][1]);
							e.changed  = 1;
						end
					end
					upd_expected.insert(upd_expected.size(), e);
				end
				default: ;
			endcase
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_result(weight_res_t got);
			weight_res_t e;
			if (upd_expected.size() == 0) begin
				weight_errs++;
				if (weight_errs <= 10)
					$display("unexpected result: entry %0d a %0d b %0d changed %0d",
						got.out_entry, got.weight_a, got.weight_b, got.changed);
				return;
			end
			e = upd_expected.pop_front();
			if (got.out_entry !== e.out_entry || got.weight_a !== e.weight_a ||
				got.weight_b !== e.weight_b || got.changed !== e.changed) begin
				weight_errs++;
				if (weight_errs <= 10)
					$display({"mismatch: exp entry %0d a %0d b %0d ch %0d, ",
						"got entry %0d a %0d b %0d ch %0d"},
						e.out_entry, e.weight_a, e.weight_b, e.changed,
						got.out_entry, got.weight_a, got.weight_b, got.changed);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	adg_in_if  in_ch ();
	adg_out_if out_ch ();

	adagrad_weight_update_table_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	weight_table_sb sb = new();
	bit             quiet;
	int             hold_asks;
	int             hold_done;
	int             stall_left;
	logic [15:0]    pool[8];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("FAILURE");
		$finish;
	end

	// result side: check transfers, drive ready with stall bursts and long holds
	initial begin
		out_ch.ready <= 0;
		stall_left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_result('{out_ch.out_entry, out_ch.weight_a, out_ch.weight_b,
					out_ch.changed});
			if (hold_asks != hold_done) begin
				hold_done++;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		sb.set_reg(idx, v);
	endtask

	task automatic send(upd_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid  <= 1;
		in_ch.cmd    <= it.cmd;
		in_ch.entry  <= it.entry;
		in_ch.grad_a <= it.grad_a;
		in_ch.grad_b <= it.grad_b;
		in_ch.load_a <= it.load_a;
		in_ch.load_b <= it.load_b;
		in_ch.epoch  <= it.epoch;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item(it);
	endtask

	// sender stops until every update result has come back
	task automatic drain();
		@(posedge clk);
		in_ch.valid <= 0;
		while (sb.upd_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_grad();
		case ($urandom_range(0, 6))
			0: return $urandom;
			1: return $urandom_range(0, 4095) * ($urandom_range(0, 1) ? 1 : -1);
			2: return $urandom_range(0, 1 << 26) * ($urandom_range(0, 1) ? 1 : -1);
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5: return 0;
			default: return $urandom_range(0, 1 << 22) * ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	function automatic logic [31:0] pick_epoch();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'(sb.warmup);
			2: return 32'(sb.warmup + 1);
			3: return 32'hFFFF_FFFF;
			4: return $urandom;
			default: return 32'(sb.warmup + $urandom_range(1, 1000));
		endcase
	endfunction

	function automatic upd_item_t mk_item(logic [1:0] cmd, logic [15:0] ent);
		upd_item_t it;
		it.cmd    = cmd;
		it.entry  = ent;
		it.grad_a = pick_grad();
		it.grad_b = pick_grad();
		it.load_a = 18'($urandom);
		it.load_b = 18'($urandom);
		it.epoch  = pick_epoch();
		return it;
	endfunction

	task automatic configure(int step, int floor, int warm, int low, int high);
		drain();
		reg_write(adg_pkg::REG_STEP, step);
		reg_write(adg_pkg::REG_FLOOR, floor);
		reg_write(adg_pkg::REG_WARMUP, warm);
		reg_write(adg_pkg::REG_LOW, low);
		reg_write(adg_pkg::REG_HIGH, high);
	endtask

	// one phase of random traffic over a small pool of loaded entries
	task automatic random_phase(bit pressure);
		int          r;
		logic [15:0] ent;
		pool[0] = 0;
		pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++) pool[i] = 16'($urandom_range(0, 65535));
		for (int i = 0; i < 8; i++) send(mk_item(adg_pkg::CMD_LOAD, pool[i]));
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (pressure && n == 80) hold_asks++;
			if (pressure && n == 200) drain();
			r = $urandom_range(0, 99);
			ent = pool[$urandom_range(0, 7)];
			if (r < 45) send(mk_item(adg_pkg::CMD_ADD, ent));
			else if (r < 82) send(mk_item(adg_pkg::CMD_UPDATE, ent));
			else if (r < 92) send(mk_item(adg_pkg::CMD_LOAD, ent));
			else send(mk_item(CMD_NONE, 16'($urandom)));
		end
	endtask

	initial begin
		upd_item_t it;
		arst_n      = 0;
		quiet       = 0;
		hold_asks   = 0;
		psel        <= 0;
		penable     <= 0;
		pwrite      <= 0;
		paddr       <= 0;
		pwdata      <= 0;
		in_ch.valid <= 0;
		in_ch.cmd   <= adg_pkg::CMD_ADD;
		in_ch.entry <= 0;
		in_ch.grad_a <= 0;
		in_ch.grad_b <= 0;
		in_ch.load_a <= 0;
		in_ch.load_b <= 0;
		in_ch.epoch <= 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, saturation, zero pending, warmup edge, ignored command
		it = mk_item(adg_pkg::CMD_LOAD, 0);
		it.load_a = 18'sh1FFFF; it.load_b = -18'sd131072;
		send(it);
		it = mk_item(adg_pkg::CMD_LOAD, 16'hFFFF);
		it.load_a = -18'sd131072; it.load_b = 18'sh1FFFF;
		send(it);
		it = mk_item(adg_pkg::CMD_UPDATE, 0);
		send(it);
		it = mk_item(adg_pkg::CMD_ADD, 0);
		it.grad_a = 32'h7FFF_FFFF; it.grad_b = 32'h8000_0000;
		send(it);
		send(it);
		it = mk_item(adg_pkg::CMD_UPDATE, 0);
		it.epoch = adg_pkg::RST_WARMUP;
		send(it);
		it = mk_item(adg_pkg::CMD_ADD, 0);
		it.grad_a = 32'h0100_0000; it.grad_b = -32'sd5;
		send(it);
		it = mk_item(adg_pkg::CMD_UPDATE, 0);
		it.epoch = adg_pkg::RST_WARMUP + 1;
		send(it);
		it = mk_item(adg_pkg::CMD_ADD, 16'hFFFF);
		it.grad_a = -32'sh0300_0000; it.grad_b = 32'h7FFF_FFFF;
		send(it);
		it = mk_item(adg_pkg::CMD_UPDATE, 16'hFFFF);
		it.epoch = 32'hFFFF_FFFF;
		send(it);
		it = mk_item(CMD_NONE, 16'hFFFF);
		send(it);
		it = mk_item(adg_pkg::CMD_UPDATE, 16'hFFFF);
		send(it);

		random_phase(0);
		configure(24'hFFFFFF, 0, 0, -131072, 131068);
		random_phase(1);
		configure(0, 16777216, 65535, 0, 0);
		random_phase(0);
		configure(24'hFFFFFF, 1000, 5, -20, 20);
		random_phase(0);
		configure($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1 << 22),
			$urandom_range(0, 20), -$urandom_range(0, 131072), $urandom_range(0, 131068));
		random_phase(0);
		configure($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1 << 24),
			$urandom_range(0, 20), -$urandom_range(0, 131072), $urandom_range(0, 131068));
		quiet = 1;
		random_phase(0);
		drain();

		if (sb.weight_errs == 0 && sb.upd_expected.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
